### hdl/cear_pkg.sv
// ----------------------------------------------------------------------------
// cear_pkg
// Shared types and codes for the CPU effective address resolver.
// ----------------------------------------------------------------------------
package cear_pkg;

    localparam int unsigned AddrWidth = 24;

    typedef enum logic [1:0] {
        CMD_WRITE_REG = 2'd0,
        CMD_RESOLVE   = 2'd1,
        CMD_READ_DATA = 2'd2,
        CMD_NOP       = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        REG_X     = 4'd0,
        REG_Y     = 4'd1,
        REG_ACC   = 4'd2,
        REG_SP    = 4'd3,
        REG_DP    = 4'd4,
        REG_PC    = 4'd5,
        REG_DBANK = 4'd6,
        REG_PBANK = 4'd7,
        REG_WIDTH = 4'd8
    } t_reg_sel;

    typedef enum logic [4:0] {
        AM_ABS          = 5'd0,
        AM_ABS_X        = 5'd1,
        AM_ABS_Y        = 5'd2,
        AM_ABS_X_IND    = 5'd3,
        AM_ABS_IND      = 5'd4,
        AM_ABS_IND_LONG = 5'd5,
        AM_LONG         = 5'd6,
        AM_LONG_X       = 5'd7,
        AM_ACC          = 5'd8,
        AM_BLOCK_MOVE   = 5'd9,
        AM_DP           = 5'd10,
        AM_DP_X         = 5'd11,
        AM_DP_Y         = 5'd12,
        AM_DP_X_IND     = 5'd13,
        AM_DP_IND       = 5'd14,
        AM_DP_IND_LONG  = 5'd15,
        AM_DP_IND_Y     = 5'd16,
        AM_DP_LONG_Y    = 5'd17,
        AM_IMMEDIATE    = 5'd18,
        AM_PC_REL       = 5'd19,
        AM_PC_REL_LONG  = 5'd20,
        AM_STACK_ABS    = 5'd21,
        AM_STACK_DP_IND = 5'd22,
        AM_STACK_PC_REL = 5'd23,
        AM_STACK_REL    = 5'd24,
        AM_STACK_REL_Y  = 5'd25
    } t_mode;

    typedef enum logic [2:0] {
        AT_NONE      = 3'd0,
        AT_MEMORY    = 3'd1,
        AT_ACC       = 3'd2,
        AT_BLOCK     = 3'd3,
        AT_IMMEDIATE = 3'd4,
        AT_STACK     = 3'd5
    } t_addr_type;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [AddrWidth-1:0] read_address;
        t_addr_type           addr_type;
        logic [AddrWidth-1:0] effective_address;
        logic [15:0]          block_source;
        logic [15:0]          block_destination;
        logic [16:0]          block_count;
    } t_result;

endpackage

### hdl/cpu_effective_address_resolver.sv
// ----------------------------------------------------------------------------
// cpu_effective_address_resolver
// Register shadow and addressing-mode resolver with pointer byte fetches.
//
//   channel | direction | handshake                | payload
//   in      | input     | i_in_valid / o_in_stall  | cmd, register, mode, operand, read data
//   out     | output    | o_out_valid / i_out_stall| kind, read address, type, address, block
//
// One item per cycle unless stalled; any result follows in the cycle after acceptance.
// Indirect modes take one read-data item per pointer byte (two or three).
// Synchronous active-low reset clears every CPU register copy and the fetch state.
// The input stalls only while a result is held and the output is stalled.
// ----------------------------------------------------------------------------
module cpu_effective_address_resolver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_register_select,
    input  logic [15:0] i_register_value,
    input  logic [4:0]  i_address_mode,
    input  logic        i_transfer_control,
    input  logic [23:0] i_operand,
    input  logic [7:0]  i_read_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [23:0] o_read_address,
    output logic [2:0]  o_address_type,
    output logic [23:0] o_effective_address,
    output logic [15:0] o_block_source,
    output logic [15:0] o_block_destination,
    output logic [16:0] o_block_count
);

    logic [15:0] r_x, n_x;
    logic [15:0] r_y, n_y;
    logic        r_x_narrow, n_x_narrow;
    logic        r_y_narrow, n_y_narrow;
    logic [15:0] r_acc, n_acc;
    logic [15:0] r_sp, n_sp;
    logic [15:0] r_dp, n_dp;
    logic [15:0] r_pc, n_pc;
    logic [7:0]  r_dbank, n_dbank;
    logic [7:0]  r_pbank, n_pbank;
    logic [4:0]  r_pend_mode, n_pend_mode;
    logic [23:0] r_pend_base, n_pend_base;
    logic [23:0] r_read_ptr, n_read_ptr;
    logic [1:0]  r_bytes, n_bytes;
    logic        r_fetch, n_fetch;

    logic                r_out_valid;
    cear_pkg::t_result   r_out;
    cear_pkg::t_result   n_out;
    logic                n_emit;

    logic        accept;
    logic [23:0] xval, yval, dbk, pbk, o8, o16, dp24, sp24;
    logic [23:0] rel8, rel16, pc24;
    logic [23:0] next_base;
    logic [1:0]  next_bytes;
    logic [1:0]  need;
    logic        is_long;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign xval  = {8'd0, (r_x_narrow ? {8'd0, r_x[7:0]} : r_x)};
    assign yval  = {8'd0, (r_y_narrow ? {8'd0, r_y[7:0]} : r_y)};
    assign dbk   = {r_dbank, 16'd0};
    assign pbk   = {r_pbank, 16'd0};
    assign o8    = {16'd0, i_operand[7:0]};
    assign o16   = {8'd0, i_operand[15:0]};
    assign dp24  = {8'd0, r_dp};
    assign sp24  = {8'd0, r_sp};
    assign pc24  = {8'd0, r_pc};
    assign rel8  = {{16{i_operand[7]}}, i_operand[7:0]};
    assign rel16 = {{8{i_operand[15]}}, i_operand[15:0]};

    assign is_long = (r_pend_mode == cear_pkg::AM_ABS_IND_LONG)
                  || (r_pend_mode == cear_pkg::AM_DP_IND_LONG)
                  || (r_pend_mode == cear_pkg::AM_DP_LONG_Y);
    assign need       = is_long ? 2'd3 : 2'd2;
    assign next_bytes = r_bytes + 2'd1;
    always_comb begin
        case (r_bytes)
            2'd0:    next_base = r_pend_base + {16'd0, i_read_data};
            2'd1:    next_base = r_pend_base + {8'd0, i_read_data, 8'd0};
            2'd2:    next_base = r_pend_base + {i_read_data, 16'd0};
            default: next_base = r_pend_base;
        endcase
    end

    always_comb begin
        n_x         = r_x;
        n_y         = r_y;
        n_x_narrow  = r_x_narrow;
        n_y_narrow  = r_y_narrow;
        n_acc       = r_acc;
        n_sp        = r_sp;
        n_dp        = r_dp;
        n_pc        = r_pc;
        n_dbank     = r_dbank;
        n_pbank     = r_pbank;
        n_pend_mode = r_pend_mode;
        n_pend_base = r_pend_base;
        n_read_ptr  = r_read_ptr;
        n_bytes     = r_bytes;
        n_fetch     = r_fetch;
        n_emit      = 1'b0;
        n_out       = '0;
        n_out.kind  = cear_pkg::KIND_FINAL;
        n_out.addr_type = cear_pkg::AT_NONE;

        case (cear_pkg::t_cmd'(i_cmd))
            cear_pkg::CMD_WRITE_REG: begin
                case (cear_pkg::t_reg_sel'(i_register_select))
                    cear_pkg::REG_X:     n_x = i_register_value;
                    cear_pkg::REG_Y:     n_y = i_register_value;
                    cear_pkg::REG_ACC:   n_acc = i_register_value;
                    cear_pkg::REG_SP:    n_sp = i_register_value;
                    cear_pkg::REG_DP:    n_dp = i_register_value;
                    cear_pkg::REG_PC:    n_pc = i_register_value;
                    cear_pkg::REG_DBANK: n_dbank = i_register_value[7:0];
                    cear_pkg::REG_PBANK: n_pbank = i_register_value[7:0];
                    cear_pkg::REG_WIDTH: begin
                        n_x_narrow = i_register_value[0];
                        n_y_narrow = i_register_value[1];
                    end
                    default: ;
                endcase
            end
            cear_pkg::CMD_READ_DATA: begin
                if (r_fetch) begin
                    n_emit      = 1'b1;
                    n_pend_base = next_base;
                    n_bytes     = next_bytes;
                    if (next_bytes < need) begin
                        n_out.kind         = cear_pkg::KIND_READ;
                        n_out.read_address = r_read_ptr + {22'd0, next_bytes};
                    end else begin
                        n_fetch = 1'b0;
                        n_out.addr_type = ((r_pend_mode == cear_pkg::AM_STACK_DP_IND)
                                        || (r_pend_mode == cear_pkg::AM_STACK_REL_Y))
                                        ? cear_pkg::AT_STACK : cear_pkg::AT_MEMORY;
                        n_out.effective_address = next_base;
                    end
                end
            end
            cear_pkg::CMD_RESOLVE: begin
                n_emit  = 1'b1;
                n_fetch = 1'b0;
                n_out.addr_type = cear_pkg::AT_MEMORY;
                n_pend_mode = i_address_mode;
                n_bytes     = 2'd0;
                case (cear_pkg::t_mode'(i_address_mode))
                    cear_pkg::AM_ABS:
                        n_out.effective_address = o16 + (i_transfer_control ? pbk : dbk);
                    cear_pkg::AM_ABS_X:  n_out.effective_address = o16 + dbk + xval;
                    cear_pkg::AM_ABS_Y:  n_out.effective_address = o16 + dbk + yval;
                    cear_pkg::AM_ABS_X_IND: begin
                        n_fetch = 1'b1;
                        n_read_ptr = o16 + xval + pbk;
                        n_pend_base = pbk;
                    end
                    cear_pkg::AM_ABS_IND: begin
                        n_fetch = 1'b1;
                        n_read_ptr = o16;
                        n_pend_base = pbk;
                    end
                    cear_pkg::AM_ABS_IND_LONG: begin
                        n_fetch = 1'b1;
                        n_read_ptr = o16;
                        n_pend_base = '0;
                    end
                    cear_pkg::AM_LONG:   n_out.effective_address = i_operand;
                    cear_pkg::AM_LONG_X: n_out.effective_address = i_operand + xval;
                    cear_pkg::AM_ACC:    n_out.addr_type = cear_pkg::AT_ACC;
                    cear_pkg::AM_BLOCK_MOVE: begin
                        n_out.addr_type         = cear_pkg::AT_BLOCK;
                        n_out.block_source      = xval[15:0];
                        n_out.block_destination = yval[15:0];
                        n_out.block_count       = {1'b0, r_acc} + 17'd1;
                    end
                    cear_pkg::AM_DP:   n_out.effective_address = o8 + dp24;
                    cear_pkg::AM_DP_X: n_out.effective_address = o8 + dp24 + xval;
                    cear_pkg::AM_DP_Y: n_out.effective_address = o8 + dp24 + yval;
                    cear_pkg::AM_DP_X_IND: begin
                        n_fetch = 1'b1;
                        n_read_ptr = dp24 + xval + o8;
                        n_pend_base = dbk;
                    end
                    cear_pkg::AM_DP_IND, cear_pkg::AM_STACK_DP_IND: begin
                        n_fetch = 1'b1;
                        n_read_ptr = o8 + dp24;
                        n_pend_base = dbk;
                    end
                    cear_pkg::AM_DP_IND_LONG: begin
                        n_fetch = 1'b1;
                        n_read_ptr = o8 + dp24;
                        n_pend_base = '0;
                    end
                    cear_pkg::AM_DP_IND_Y: begin
                        n_fetch = 1'b1;
                        n_read_ptr = o8 + dp24;
                        n_pend_base = dbk + yval;
                    end
                    cear_pkg::AM_DP_LONG_Y: begin
                        n_fetch = 1'b1;
                        n_read_ptr = o8 + dp24;
                        n_pend_base = yval;
                    end
                    cear_pkg::AM_IMMEDIATE: begin
                        n_out.addr_type = cear_pkg::AT_IMMEDIATE;
                        n_out.effective_address = o16;
                    end
                    cear_pkg::AM_PC_REL:      n_out.effective_address = pc24 + pbk + rel8;
                    cear_pkg::AM_PC_REL_LONG: n_out.effective_address = pc24 + pbk + rel16;
                    cear_pkg::AM_STACK_ABS: begin
                        n_out.addr_type = cear_pkg::AT_STACK;
                        n_out.effective_address = o16;
                    end
                    cear_pkg::AM_STACK_PC_REL: begin
                        n_out.addr_type = cear_pkg::AT_STACK;
                        n_out.effective_address = pc24 + pbk + rel16;
                    end
                    cear_pkg::AM_STACK_REL: begin
                        n_out.addr_type = cear_pkg::AT_STACK;
                        n_out.effective_address = o8 + sp24;
                    end
                    cear_pkg::AM_STACK_REL_Y: begin
                        n_fetch = 1'b1;
                        n_read_ptr = o8 + sp24;
                        n_pend_base = dbk + yval;
                    end
                    default: n_out.addr_type = cear_pkg::AT_NONE;
                endcase
                if (n_fetch) begin
                    n_out.kind         = cear_pkg::KIND_READ;
                    n_out.addr_type    = cear_pkg::AT_NONE;
                    n_out.read_address = n_read_ptr;
                end else begin
                    n_pend_mode = r_pend_mode;
                    n_bytes     = r_bytes;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x         <= '0;
            r_y         <= '0;
            r_x_narrow  <= 1'b0;
            r_y_narrow  <= 1'b0;
            r_acc       <= '0;
            r_sp        <= '0;
            r_dp        <= '0;
            r_pc        <= '0;
            r_dbank     <= '0;
            r_pbank     <= '0;
            r_pend_mode <= '0;
            r_pend_base <= '0;
            r_read_ptr  <= '0;
            r_bytes     <= '0;
            r_fetch     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_x         <= n_x;
                r_y         <= n_y;
                r_x_narrow  <= n_x_narrow;
                r_y_narrow  <= n_y_narrow;
                r_acc       <= n_acc;
                r_sp        <= n_sp;
                r_dp        <= n_dp;
                r_pc        <= n_pc;
                r_dbank     <= n_dbank;
                r_pbank     <= n_pbank;
                r_pend_mode <= n_pend_mode;
                r_pend_base <= n_pend_base;
                r_read_ptr  <= n_read_ptr;
                r_bytes     <= n_bytes;
                r_fetch     <= n_fetch;
            end
            if (accept && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_result_kind       = r_out.kind;
    assign o_read_address      = r_out.read_address;
    assign o_address_type      = r_out.addr_type;
    assign o_effective_address = r_out.effective_address;
    assign o_block_source      = r_out.block_source;
    assign o_block_destination = r_out.block_destination;
    assign o_block_count       = r_out.block_count;

    a_read_req_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == cear_pkg::KIND_READ) |->
        (r_out.addr_type == cear_pkg::AT_NONE && r_out.effective_address == '0))
        else $error("read request carries a resolved address");

    a_final_no_raddr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == cear_pkg::KIND_FINAL) |-> (r_out.read_address == '0))
        else $error("final answer carries a read address");

    a_block_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.addr_type != cear_pkg::AT_BLOCK) |->
        (r_out.block_count == '0 && r_out.block_source == '0
         && r_out.block_destination == '0))
        else $error("block fields set outside block move");

    a_fetch_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fetch |-> (r_bytes != 2'd3))
        else $error("fetch active after three pointer bytes");

    a_read_leaves_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_emit && n_out.kind == cear_pkg::KIND_READ) |=> r_fetch)
        else $error("read request issued without an active fetch");

endmodule

### verif/cear_address_checker.sv
// ----------------------------------------------------------------------------
// cear_address_checker
// Watches both channels of the effective address resolver. It keeps its own
// copy of the CPU registers and the pointer fetch state. It works out the
// answer, if any, for each accepted input beat and compares every accepted
// output beat, field by field, against the oldest answer still waiting.
// ----------------------------------------------------------------------------
module cear_address_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_register_select,
    input  logic [15:0] i_register_value,
    input  logic [4:0]  i_address_mode,
    input  logic        i_transfer_control,
    input  logic [23:0] i_operand,
    input  logic [7:0]  i_read_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_result_kind,
    input  logic [23:0] i_read_address,
    input  logic [2:0]  i_address_type,
    input  logic [23:0] i_effective_address,
    input  logic [15:0] i_block_source,
    input  logic [15:0] i_block_destination,
    input  logic [16:0] i_block_count,
    output int          o_error_count,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] x_reg, y_reg, acc_reg, sp_reg, dp_reg, pc_reg;
    logic        x_narrow, y_narrow;
    logic [7:0]  dbank_reg, pbank_reg;
    logic [4:0]  fetch_mode;
    logic [23:0] fetch_base;
    logic [23:0] fetch_ptr;
    logic [1:0]  fetch_count;
    logic        fetching;

    cear_pkg::t_result address_answers[$];

    function automatic logic [23:0] x_index();
        return x_narrow ? {16'h0, x_reg[7:0]} : {8'h0, x_reg};
    endfunction

    function automatic logic [23:0] y_index();
        return y_narrow ? {16'h0, y_reg[7:0]} : {8'h0, y_reg};
    endfunction

    function automatic logic [23:0] data_bank();
        return {dbank_reg, 16'h0};
    endfunction

    function automatic logic [23:0] prog_bank();
        return {pbank_reg, 16'h0};
    endfunction

    function automatic logic [23:0] pc_target(logic [15:0] off, logic wide);
        logic [23:0] ext;
        ext = wide ? {{8{off[15]}}, off} : {{16{off[7]}}, off[7:0]};
        return {8'h0, pc_reg} + prog_bank() + ext;
    endfunction

    function automatic cear_pkg::t_result final_answer(cear_pkg::t_addr_type at,
                                                       logic [23:0] ea);
        cear_pkg::t_result r;
        r = '0;
        r.kind = cear_pkg::KIND_FINAL;
        r.addr_type = at;
        r.effective_address = ea;
        return r;
    endfunction

    function automatic cear_pkg::t_result pointer_read(logic [23:0] addr);
        cear_pkg::t_result r;
        r = '0;
        r.kind = cear_pkg::KIND_READ;
        r.addr_type = cear_pkg::AT_NONE;
        r.read_address = addr;
        return r;
    endfunction

    task automatic begin_fetch(logic [4:0] mode, logic [23:0] ptr, logic [23:0] base);
        fetch_mode = mode;
        fetch_base = base;
        fetch_ptr = ptr;
        fetch_count = '0;
        fetching = 1'b1;
        address_answers.push_back(pointer_read(ptr));
    endtask

    task automatic resolve_item();
        logic [23:0] o8, o16, dp24, sp24, idx;
        logic        long_ptr;
        cear_pkg::t_result r;
        o8 = {16'h0, i_operand[7:0]};
        o16 = {8'h0, i_operand[15:0]};
        dp24 = {8'h0, dp_reg};
        sp24 = {8'h0, sp_reg};
        case (i_cmd)
            cear_pkg::CMD_WRITE_REG: begin
                case (i_register_select)
                    cear_pkg::REG_X:     x_reg = i_register_value;
                    cear_pkg::REG_Y:     y_reg = i_register_value;
                    cear_pkg::REG_ACC:   acc_reg = i_register_value;
                    cear_pkg::REG_SP:    sp_reg = i_register_value;
                    cear_pkg::REG_DP:    dp_reg = i_register_value;
                    cear_pkg::REG_PC:    pc_reg = i_register_value;
                    cear_pkg::REG_DBANK: dbank_reg = i_register_value[7:0];
                    cear_pkg::REG_PBANK: pbank_reg = i_register_value[7:0];
                    cear_pkg::REG_WIDTH: begin
                        x_narrow = i_register_value[0];
                        y_narrow = i_register_value[1];
                    end
                    default: ;
                endcase
            end
            cear_pkg::CMD_READ_DATA: begin
                if (fetching) begin
                    fetch_base = fetch_base + ({16'h0, i_read_data} << (8 * fetch_count));
                    fetch_count = fetch_count + 2'd1;
                    long_ptr = (fetch_mode == cear_pkg::AM_ABS_IND_LONG)
                        || (fetch_mode == cear_pkg::AM_DP_IND_LONG)
                        || (fetch_mode == cear_pkg::AM_DP_LONG_Y);
                    if (fetch_count < (long_ptr ? 2'd3 : 2'd2)) begin
                        address_answers.push_back(
                            pointer_read(fetch_ptr + {22'd0, fetch_count}));
                    end else begin
                        fetching = 1'b0;
                        if (fetch_mode == cear_pkg::AM_STACK_DP_IND
                            || fetch_mode == cear_pkg::AM_STACK_REL_Y) begin
                            address_answers.push_back(
                                final_answer(cear_pkg::AT_STACK, fetch_base));
                        end else begin
                            address_answers.push_back(
                                final_answer(cear_pkg::AT_MEMORY, fetch_base));
                        end
                    end
                end
            end
            cear_pkg::CMD_RESOLVE: begin
                fetching = 1'b0;
                case (i_address_mode)
                    cear_pkg::AM_ABS: address_answers.push_back(
                        final_answer(cear_pkg::AT_MEMORY,
                        o16 + (i_transfer_control ? prog_bank() : data_bank())));
                    cear_pkg::AM_ABS_X: address_answers.push_back(
                        final_answer(cear_pkg::AT_MEMORY, o16 + data_bank() + x_index()));
                    cear_pkg::AM_ABS_Y: address_answers.push_back(
                        final_answer(cear_pkg::AT_MEMORY, o16 + data_bank() + y_index()));
                    cear_pkg::AM_ABS_X_IND: begin_fetch(i_address_mode,
                        o16 + x_index() + prog_bank(), prog_bank());
                    cear_pkg::AM_ABS_IND: begin_fetch(i_address_mode, o16, prog_bank());
                    cear_pkg::AM_ABS_IND_LONG: begin_fetch(i_address_mode, o16, '0);
                    cear_pkg::AM_LONG: address_answers.push_back(
                        final_answer(cear_pkg::AT_MEMORY, i_operand));
                    cear_pkg::AM_LONG_X: address_answers.push_back(
                        final_answer(cear_pkg::AT_MEMORY, i_operand + x_index()));
                    cear_pkg::AM_ACC: address_answers.push_back(
                        final_answer(cear_pkg::AT_ACC, '0));
                    cear_pkg::AM_BLOCK_MOVE: begin
                        r = final_answer(cear_pkg::AT_BLOCK, '0);
                        idx = x_index();
                        r.block_source = idx[15:0];
                        idx = y_index();
                        r.block_destination = idx[15:0];
                        r.block_count = {1'b0, acc_reg} + 17'd1;
                        address_answers.push_back(r);
                    end
                    cear_pkg::AM_DP: address_answers.push_back(
                        final_answer(cear_pkg::AT_MEMORY, o8 + dp24));
                    cear_pkg::AM_DP_X: address_answers.push_back(
                        final_answer(cear_pkg::AT_MEMORY, o8 + dp24 + x_index()));
                    cear_pkg::AM_DP_Y: address_answers.push_back(
                        final_answer(cear_pkg::AT_MEMORY, o8 + dp24 + y_index()));
                    cear_pkg::AM_DP_X_IND: begin_fetch(i_address_mode,
                        dp24 + x_index() + o8, data_bank());
                    cear_pkg::AM_DP_IND: begin_fetch(i_address_mode, o8 + dp24, data_bank());
                    cear_pkg::AM_DP_IND_LONG: begin_fetch(i_address_mode, o8 + dp24, '0);
                    cear_pkg::AM_DP_IND_Y: begin_fetch(i_address_mode, o8 + dp24,
                        data_bank() + y_index());
                    cear_pkg::AM_DP_LONG_Y: begin_fetch(i_address_mode, o8 + dp24, y_index());
                    cear_pkg::AM_IMMEDIATE: address_answers.push_back(
                        final_answer(cear_pkg::AT_IMMEDIATE, o16));
                    cear_pkg::AM_PC_REL: address_answers.push_back(
                        final_answer(cear_pkg::AT_MEMORY, pc_target(i_operand[15:0], 1'b0)));
                    cear_pkg::AM_PC_REL_LONG: address_answers.push_back(
                        final_answer(cear_pkg::AT_MEMORY, pc_target(i_operand[15:0], 1'b1)));
                    cear_pkg::AM_STACK_ABS: address_answers.push_back(
                        final_answer(cear_pkg::AT_STACK, o16));
                    cear_pkg::AM_STACK_DP_IND: begin_fetch(i_address_mode, o8 + dp24,
                        data_bank());
                    cear_pkg::AM_STACK_PC_REL: address_answers.push_back(
                        final_answer(cear_pkg::AT_STACK, pc_target(i_operand[15:0], 1'b1)));
                    cear_pkg::AM_STACK_REL: address_answers.push_back(
                        final_answer(cear_pkg::AT_STACK, o8 + sp24));
                    cear_pkg::AM_STACK_REL_Y: begin_fetch(i_address_mode, o8 + sp24,
                        data_bank() + y_index());
                    default: address_answers.push_back(final_answer(cear_pkg::AT_NONE, '0));
                endcase
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            o_error_count++;
        end
    endtask

    task automatic check_result();
        cear_pkg::t_result want;
        if (address_answers.size() == 0) begin
            $display("%0t: unexpected result beat, actual kind %0d type %0d address %h",
                $time, i_result_kind, i_address_type, i_effective_address);
            o_error_count++;
        end else begin
            want = address_answers.pop_front();
            check_field("result_kind", 24'(want.kind), 24'(i_result_kind));
            check_field("read_address", want.read_address, i_read_address);
            check_field("address_type", 24'(want.addr_type), 24'(i_address_type));
            check_field("effective_address", want.effective_address, i_effective_address);
            check_field("block_source", 24'(want.block_source), 24'(i_block_source));
            check_field("block_destination", 24'(want.block_destination),
                24'(i_block_destination));
            check_field("block_count", 24'(want.block_count), 24'(i_block_count));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            x_reg = '0;
            y_reg = '0;
            acc_reg = '0;
            sp_reg = '0;
            dp_reg = '0;
            pc_reg = '0;
            x_narrow = 1'b0;
            y_narrow = 1'b0;
            dbank_reg = '0;
            pbank_reg = '0;
            fetch_mode = '0;
            fetch_base = '0;
            fetch_ptr = '0;
            fetch_count = '0;
            fetching = 1'b0;
            address_answers.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
            if (i_in_valid && !i_in_stall) begin
                resolve_item();
            end
        end
        o_outstanding = address_answers.size();
    end

endmodule

### verif/tb_cpu_effective_address_resolver.sv
// ----------------------------------------------------------------------------
// tb_cpu_effective_address_resolver
// Drives register writes, resolve requests and pointer byte returns into the
// effective address resolver: a directed opening, then random well-formed
// fetch sequences mixed with noise, under four idle and stall phases.
// A checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_cpu_effective_address_resolver;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_cmd;
    logic [3:0]  i_register_select;
    logic [15:0] i_register_value;
    logic [4:0]  i_address_mode;
    logic        i_transfer_control;
    logic [23:0] i_operand;
    logic [7:0]  i_read_data;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_result_kind;
    logic [23:0] o_read_address;
    logic [2:0]  o_address_type;
    logic [23:0] o_effective_address;
    logic [15:0] o_block_source;
    logic [15:0] o_block_destination;
    logic [16:0] o_block_count;

    int error_count;
    int outstanding;
    int idle_pct;
    int stall_pct;

    cpu_effective_address_resolver uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_cmd               (i_cmd),
        .i_register_select   (i_register_select),
        .i_register_value    (i_register_value),
        .i_address_mode      (i_address_mode),
        .i_transfer_control  (i_transfer_control),
        .i_operand           (i_operand),
        .i_read_data         (i_read_data),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_result_kind       (o_result_kind),
        .o_read_address      (o_read_address),
        .o_address_type      (o_address_type),
        .o_effective_address (o_effective_address),
        .o_block_source      (o_block_source),
        .o_block_destination (o_block_destination),
        .o_block_count       (o_block_count)
    );

    cear_address_checker checker_inst (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_cmd               (i_cmd),
        .i_register_select   (i_register_select),
        .i_register_value    (i_register_value),
        .i_address_mode      (i_address_mode),
        .i_transfer_control  (i_transfer_control),
        .i_operand           (i_operand),
        .i_read_data         (i_read_data),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_result_kind       (o_result_kind),
        .i_read_address      (o_read_address),
        .i_address_type      (o_address_type),
        .i_effective_address (o_effective_address),
        .i_block_source      (o_block_source),
        .i_block_destination (o_block_destination),
        .i_block_count       (o_block_count),
        .o_error_count       (error_count),
        .o_outstanding       (outstanding)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic drive_beat(cear_pkg::t_cmd c, logic [3:0] sel, logic [15:0] val,
                              logic [4:0] mode, logic tc, logic [23:0] op, logic [7:0] rd);
        bit  taken;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cmd <= c;
        i_register_select <= sel;
        i_register_value <= val;
        i_address_mode <= mode;
        i_transfer_control <= tc;
        i_operand <= op;
        i_read_data <= rd;
        i_in_valid <= 1'b1;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [3:0] sel, logic [15:0] val);
        drive_beat(cear_pkg::CMD_WRITE_REG, sel, val, 5'($urandom), 1'($urandom),
            24'($urandom), 8'($urandom));
    endtask

    task automatic resolve(logic [4:0] mode, logic tc, logic [23:0] op);
        drive_beat(cear_pkg::CMD_RESOLVE, 4'($urandom), 16'($urandom), mode, tc, op,
            8'($urandom));
    endtask

    task automatic return_byte(logic [7:0] rd);
        drive_beat(cear_pkg::CMD_READ_DATA, 4'($urandom), 16'($urandom), 5'($urandom),
            1'($urandom), 24'($urandom), rd);
    endtask

    function automatic int pointer_bytes(logic [4:0] mode);
        case (mode)
            cear_pkg::AM_ABS_IND_LONG, cear_pkg::AM_DP_IND_LONG,
            cear_pkg::AM_DP_LONG_Y: return 3;
            cear_pkg::AM_ABS_X_IND, cear_pkg::AM_ABS_IND, cear_pkg::AM_DP_X_IND,
            cear_pkg::AM_DP_IND, cear_pkg::AM_DP_IND_Y, cear_pkg::AM_STACK_DP_IND,
            cear_pkg::AM_STACK_REL_Y: return 2;
            default: return 0;
        endcase
    endfunction

    function automatic logic [15:0] random_word();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] random_operand();
        case ($urandom_range(7))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(255));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_reg_write();
        logic [3:0] sel;
        sel = 4'($urandom_range(8));
        write_reg(sel, (sel == cear_pkg::REG_WIDTH) ? 16'($urandom) : random_word());
    endtask

    task automatic random_stream(int beats);
        int         sent;
        int         pick;
        int         bytes;
        int         k;
        logic [4:0] mode;
        sent = 0;
        while (sent < beats) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                random_reg_write();
                sent++;
            end else if (pick < 88) begin
                if ($urandom_range(9) == 0) begin
                    mode = 5'($urandom_range(26, 31));
                end else begin
                    mode = 5'($urandom_range(25));
                end
                resolve(mode, 1'($urandom), random_operand());
                sent++;
                bytes = pointer_bytes(mode);
                // cut some fetches short so the next resolve drops them
                if (bytes != 0 && $urandom_range(9) == 0) begin
                    bytes = $urandom_range(bytes - 1);
                end
                for (k = 0; k < bytes; k++) begin
                    if ($urandom_range(7) == 0) begin
                        random_reg_write();
                        sent++;
                    end
                    return_byte(8'($urandom));
                    sent++;
                end
            end else begin
                case ($urandom_range(2))
                    0: drive_beat(cear_pkg::CMD_NOP, 4'($urandom), 16'($urandom),
                        5'($urandom), 1'($urandom), 24'($urandom), 8'($urandom));
                    1: write_reg(4'($urandom_range(9, 15)), 16'($urandom));
                    default: return_byte(8'($urandom));
                endcase
            end
        end
    endtask

    task automatic drain_answers();
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (outstanding != 0);
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cmd = cear_pkg::CMD_NOP;
        i_register_select = '0;
        i_register_value = '0;
        i_address_mode = '0;
        i_transfer_control = 1'b0;
        i_operand = '0;
        i_read_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        resolve(cear_pkg::AM_ABS, 1'b0, 24'hFFFFFF);
        write_reg(cear_pkg::REG_X, 16'hFFFF);
        write_reg(cear_pkg::REG_Y, 16'h8001);
        write_reg(cear_pkg::REG_ACC, 16'hFFFF);
        write_reg(cear_pkg::REG_SP, 16'hFFFF);
        write_reg(cear_pkg::REG_DP, 16'hFFF0);
        write_reg(cear_pkg::REG_PC, 16'hFFFE);
        write_reg(cear_pkg::REG_DBANK, 16'hABFF);
        write_reg(cear_pkg::REG_PBANK, 16'h00FF);
        resolve(cear_pkg::AM_BLOCK_MOVE, 1'b0, 24'h000000);
        resolve(cear_pkg::AM_LONG_X, 1'b0, 24'hFFFFFF);
        resolve(cear_pkg::AM_PC_REL, 1'b0, 24'h000080);
        resolve(cear_pkg::AM_PC_REL_LONG, 1'b1, 24'h007FFF);
        resolve(cear_pkg::AM_ABS, 1'b1, 24'h00FFFF);
        write_reg(cear_pkg::REG_WIDTH, 16'h0003);
        resolve(cear_pkg::AM_DP_LONG_Y, 1'b0, 24'h0000FF);
        write_reg(cear_pkg::REG_X, 16'h0000);
        return_byte(8'hFF);
        resolve(cear_pkg::AM_STACK_REL_Y, 1'b0, 24'h0000FF);
        return_byte(8'h00);
        return_byte(8'h80);
        return_byte(8'h5A);
        drive_beat(cear_pkg::CMD_NOP, 4'hF, 16'hFFFF, 5'h1F, 1'b1, 24'hFFFFFF, 8'hFF);
        write_reg(4'hF, 16'hFFFF);
        resolve(5'd31, 1'b1, 24'hFFFFFF);
        drain_answers();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            random_stream(220);
            drain_answers();
        end

        stall_pct = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
